// ----- src/script_lexer_byte_tokenizer_macros.svh -----
// assertion macros shared by the tokenizer rtl
// expects signals named clock and reset in the using scope
`ifndef SCRIPT_LEXER_BYTE_TOKENIZER_MACROS_SVH
`define SCRIPT_LEXER_BYTE_TOKENIZER_MACROS_SVH

// same-cycle implication
`define SLT_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define SLT_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- src/sltok_pkg.sv -----
// types, token codes and helper functions for the byte tokenizer
// no dependencies
`timescale 1ns / 1ps

package sltok_pkg;

   localparam int POS_BITS = 24;
   localparam int LINE_BITS = 24;
   localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};
   localparam logic [POS_BITS-1:0] POS_ONE = {{(POS_BITS-1){1'b0}}, 1'b1};
   localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};

   typedef enum logic [3:0] {
      MODE_IDLE    = 4'd0,
      MODE_OP      = 4'd1,
      MODE_SLASH   = 4'd2,
      MODE_COMMENT = 4'd3,
      MODE_STRING  = 4'd4,
      MODE_INT     = 4'd5,
      MODE_FRAC    = 4'd6,
      MODE_WORD    = 4'd7
   } mode_type;

   localparam logic [1:0] KIND_TOKEN = 2'd0;
   localparam logic [1:0] KIND_BAD_CHAR = 2'd1;
   localparam logic [1:0] KIND_OPEN_STRING = 2'd2;

   localparam logic [5:0] TOK_LPAREN = 6'd0;
   localparam logic [5:0] TOK_RPAREN = 6'd1;
   localparam logic [5:0] TOK_LBRACE = 6'd2;
   localparam logic [5:0] TOK_RBRACE = 6'd3;
   localparam logic [5:0] TOK_COMMA = 6'd4;
   localparam logic [5:0] TOK_SEMI = 6'd5;
   localparam logic [5:0] TOK_DOT = 6'd6;
   localparam logic [5:0] TOK_QUESTION = 6'd7;
   localparam logic [5:0] TOK_COLON = 6'd8;
   localparam logic [5:0] TOK_PLUS = 6'd9;
   localparam logic [5:0] TOK_MINUS = 6'd10;
   localparam logic [5:0] TOK_STAR = 6'd11;
   localparam logic [5:0] TOK_SLASH = 6'd12;
   localparam logic [5:0] TOK_BANG = 6'd13;
   localparam logic [5:0] TOK_IDENT = 6'd21;
   localparam logic [5:0] TOK_STRING = 6'd22;
   localparam logic [5:0] TOK_NUMBER = 6'd23;
   localparam logic [5:0] TOK_KW0 = 6'd24;
   localparam logic [5:0] TOK_EOF = 6'd40;

   localparam int NUM_KW = 16;
   localparam logic [47:0] KW_TEXT [NUM_KW] = '{
      48'h000000646E61, 48'h007373616C63, 48'h000065736C65, 48'h0065736C6166,
      48'h0000006E7566, 48'h000000726F66, 48'h000000006669, 48'h0000006C696E,
      48'h00000000726F, 48'h00746E697270, 48'h6E7275746572, 48'h007265707573,
      48'h000073696874, 48'h000065757274, 48'h000000726176, 48'h00656C696877
   };
   localparam logic [2:0] KW_LEN [NUM_KW] = '{
      3'd3, 3'd5, 3'd4, 3'd5, 3'd3, 3'd3, 3'd2, 3'd3,
      3'd2, 3'd5, 3'd6, 3'd5, 3'd4, 3'd4, 3'd3, 3'd5
   };

   typedef struct packed {
      mode_type             mode;
      logic [1:0]           pend;
      logic [LINE_BITS-1:0] line;
      logic [POS_BITS-1:0]  pos;
      logic [POS_BITS-1:0]  start;
      logic [47:0]          kwbuf;
      logic [2:0]           wlen;
   } state_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [5:0]  ttype;
      logic [23:0] line;
      logic [23:0] start;
      logic [23:0] len;
      logic [7:0]  bad;
      logic        last;
   } result_type;

   typedef struct packed {
      logic       vld;
      result_type res;
   } emit_type;

   function automatic logic is_dig(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
   endfunction

   function automatic emit_type mk_emit(input logic [1:0] kind, input logic [5:0] ttype,
                                        input logic [LINE_BITS-1:0] line,
                                        input logic [POS_BITS-1:0] start,
                                        input logic [POS_BITS-1:0] len,
                                        input logic [7:0] bad);
      emit_type e;
      e.vld = 1'b1;
      e.res.kind = kind;
      e.res.ttype = ttype;
      e.res.line = line[23:0];
      e.res.start = 24'(start);
      e.res.len = 24'(len);
      e.res.bad = bad;
      e.res.last = 1'b0;
      return e;
   endfunction

   // parallel compare against the keyword table
   function automatic logic [5:0] word_type(input logic [47:0] kwbuf, input logic [2:0] wlen);
      logic [5:0] t;
      t = TOK_IDENT;
      for (int k = 0; k < NUM_KW; k++) begin
         if ((wlen == KW_LEN[k]) && (kwbuf == KW_TEXT[k])) begin
            t = TOK_KW0 + 6'(k);
         end
      end
      return t;
   endfunction

   // close the pending token that ends just before cur
   function automatic emit_type flush_tok(input state_type s, input logic [POS_BITS-1:0] cur,
                                          input logic at_end);
      emit_type e;
      logic [POS_BITS-1:0] len;
      len = cur - s.start;
      e = '0;
      case (s.mode)
         MODE_OP: e = mk_emit(KIND_TOKEN, TOK_BANG + {3'd0, s.pend, 1'b0}, s.line, s.start,
                              len, 8'd0);
         MODE_SLASH: e = mk_emit(KIND_TOKEN, TOK_SLASH, s.line, s.start, len, 8'd0);
         MODE_INT, MODE_FRAC: e = mk_emit(KIND_TOKEN, TOK_NUMBER, s.line, s.start, len, 8'd0);
         MODE_WORD: e = mk_emit(KIND_TOKEN, word_type(s.kwbuf, s.wlen), s.line, s.start, len,
                                8'd0);
         MODE_STRING: begin
            if (at_end) begin
               e = mk_emit(KIND_OPEN_STRING, 6'd0, s.line, s.start, len, 8'd0);
            end
         end
         default: e = '0;
      endcase
      return e;
   endfunction

endpackage

// ----- src/sltok_scan.sv -----
// next-state and result logic for one source byte
// depends on sltok_pkg
`timescale 1ns / 1ps

module sltok_scan (
   input  sltok_pkg::state_type                  cur_state,
   input  logic [7:0]                            char_in,
   input  logic                                  is_last,
   input  logic [sltok_pkg::LINE_BITS-1:0]       first_line,
   output sltok_pkg::state_type                  next_state,
   output sltok_pkg::result_type                 res [3],
   output logic [1:0]                            res_count
);

   always_comb begin
      sltok_pkg::state_type n;
      sltok_pkg::emit_type e [4];
      logic [sltok_pkg::POS_BITS-1:0] pos;
      logic [sltok_pkg::POS_BITS-1:0] endp;
      logic used;
      logic [2:0] k;

      n = cur_state;
      pos = cur_state.pos;
      endp = (pos != sltok_pkg::POS_MAX) ? pos + 1'b1 : pos;
      used = 1'b1;
      for (int i = 0; i < 4; i++) e[i] = '0;

      case (cur_state.mode)
         sltok_pkg::MODE_OP: begin
            if (char_in == 8'h3D) begin
               e[0] = sltok_pkg::mk_emit(sltok_pkg::KIND_TOKEN,
                  sltok_pkg::TOK_BANG + {3'd0, cur_state.pend, 1'b1}, n.line, n.start,
                  endp - n.start, 8'd0);
               n.mode = sltok_pkg::MODE_IDLE;
            end else begin
               e[0] = sltok_pkg::flush_tok(cur_state, pos, 1'b0);
               used = 1'b0;
            end
         end
         sltok_pkg::MODE_SLASH: begin
            if (char_in == 8'h2F) begin
               n.mode = sltok_pkg::MODE_COMMENT;
            end else begin
               e[0] = sltok_pkg::flush_tok(cur_state, pos, 1'b0);
               used = 1'b0;
            end
         end
         sltok_pkg::MODE_COMMENT: begin
            if (char_in == 8'h0A) begin
               if (n.line != sltok_pkg::LINE_MAX) n.line = n.line + 1'b1;
               n.mode = sltok_pkg::MODE_IDLE;
            end
         end
         sltok_pkg::MODE_STRING: begin
            if (char_in == 8'h22) begin
               e[0] = sltok_pkg::mk_emit(sltok_pkg::KIND_TOKEN, sltok_pkg::TOK_STRING, n.line,
                  n.start, endp - n.start, 8'd0);
               n.mode = sltok_pkg::MODE_IDLE;
            end else if (char_in == 8'h0A) begin
               if (n.line != sltok_pkg::LINE_MAX) n.line = n.line + 1'b1;
            end
         end
         sltok_pkg::MODE_INT: begin
            if (char_in == 8'h2E) begin
               n.mode = sltok_pkg::MODE_FRAC;
            end else if (!sltok_pkg::is_dig(char_in)) begin
               e[0] = sltok_pkg::flush_tok(cur_state, pos, 1'b0);
               used = 1'b0;
            end
         end
         sltok_pkg::MODE_FRAC: begin
            if (!sltok_pkg::is_dig(char_in)) begin
               e[0] = sltok_pkg::flush_tok(cur_state, pos, 1'b0);
               used = 1'b0;
            end
         end
         sltok_pkg::MODE_WORD: begin
            if (sltok_pkg::is_alpha(char_in) || sltok_pkg::is_dig(char_in)) begin
               if (n.wlen < 3'd6) begin
                  for (int i = 0; i < 6; i++) begin
                     if (n.wlen == 3'(i)) n.kwbuf[8*i +: 8] = n.kwbuf[8*i +: 8] | char_in;
                  end
                  n.wlen = n.wlen + 1'b1;
               end else begin
                  n.wlen = 3'd7;
               end
            end else begin
               e[0] = sltok_pkg::flush_tok(cur_state, pos, 1'b0);
               used = 1'b0;
            end
         end
         default: used = 1'b0;
      endcase

      if (!used) begin
         n.mode = sltok_pkg::MODE_IDLE;
         n.start = pos;
         case (char_in)
            8'h20, 8'h09, 8'h0D: ;
            8'h0A: if (n.line != sltok_pkg::LINE_MAX) n.line = n.line + 1'b1;
            8'h28: e[1] = sltok_pkg::mk_emit(sltok_pkg::KIND_TOKEN, sltok_pkg::TOK_LPAREN,
                                             n.line, pos, sltok_pkg::POS_ONE, 8'd0);
            8'h29: e[1] = sltok_pkg::mk_emit(sltok_pkg::KIND_TOKEN, sltok_pkg::TOK_RPAREN,
                                             n.line, pos, sltok_pkg::POS_ONE, 8'd0);
            8'h7B: e[1] = sltok_pkg::mk_emit(sltok_pkg::KIND_TOKEN, sltok_pkg::TOK_LBRACE,
                                             n.line, pos, sltok_pkg::POS_ONE, 8'd0);
            8'h7D: e[1] = sltok_pkg::mk_emit(sltok_pkg::KIND_TOKEN, sltok_pkg::TOK_RBRACE,
                                             n.line, pos, sltok_pkg::POS_ONE, 8'd0);
            8'h2C: e[1] = sltok_pkg::mk_emit(sltok_pkg::KIND_TOKEN, sltok_pkg::TOK_COMMA,
                                             n.line, pos, sltok_pkg::POS_ONE, 8'd0);
            8'h3B: e[1] = sltok_pkg::mk_emit(sltok_pkg::KIND_TOKEN, sltok_pkg::TOK_SEMI,
                                             n.line, pos, sltok_pkg::POS_ONE, 8'd0);
            8'h2E: e[1] = sltok_pkg::mk_emit(sltok_pkg::KIND_TOKEN, sltok_pkg::TOK_DOT,
                                             n.line, pos, sltok_pkg::POS_ONE, 8'd0);
            8'h3F: e[1] = sltok_pkg::mk_emit(sltok_pkg::KIND_TOKEN, sltok_pkg::TOK_QUESTION,
                                             n.line, pos, sltok_pkg::POS_ONE, 8'd0);
            8'h3A: e[1] = sltok_pkg::mk_emit(sltok_pkg::KIND_TOKEN, sltok_pkg::TOK_COLON,
                                             n.line, pos, sltok_pkg::POS_ONE, 8'd0);
            8'h2B: e[1] = sltok_pkg::mk_emit(sltok_pkg::KIND_TOKEN, sltok_pkg::TOK_PLUS,
                                             n.line, pos, sltok_pkg::POS_ONE, 8'd0);
            8'h2D: e[1] = sltok_pkg::mk_emit(sltok_pkg::KIND_TOKEN, sltok_pkg::TOK_MINUS,
                                             n.line, pos, sltok_pkg::POS_ONE, 8'd0);
            8'h2A: e[1] = sltok_pkg::mk_emit(sltok_pkg::KIND_TOKEN, sltok_pkg::TOK_STAR,
                                             n.line, pos, sltok_pkg::POS_ONE, 8'd0);
            8'h2F: n.mode = sltok_pkg::MODE_SLASH;
            8'h21: begin n.mode = sltok_pkg::MODE_OP; n.pend = 2'd0; end
            8'h3D: begin n.mode = sltok_pkg::MODE_OP; n.pend = 2'd1; end
            8'h3C: begin n.mode = sltok_pkg::MODE_OP; n.pend = 2'd2; end
            8'h3E: begin n.mode = sltok_pkg::MODE_OP; n.pend = 2'd3; end
            8'h22: n.mode = sltok_pkg::MODE_STRING;
            default: begin
               if (sltok_pkg::is_dig(char_in)) begin
                  n.mode = sltok_pkg::MODE_INT;
               end else if (sltok_pkg::is_alpha(char_in)) begin
                  n.mode = sltok_pkg::MODE_WORD;
                  n.kwbuf = {40'd0, char_in};
                  n.wlen = 3'd1;
               end else begin
                  e[1] = sltok_pkg::mk_emit(sltok_pkg::KIND_BAD_CHAR, 6'd0, n.line, pos,
                                            sltok_pkg::POS_ONE, char_in);
               end
            end
         endcase
      end

      n.pos = endp;

      if (is_last) begin
         e[2] = sltok_pkg::flush_tok(n, endp, 1'b1);
         e[3] = sltok_pkg::mk_emit(sltok_pkg::KIND_TOKEN, sltok_pkg::TOK_EOF, n.line, endp, '0,
                                   8'd0);
         n = '0;
         n.mode = sltok_pkg::MODE_IDLE;
         n.line = first_line;
      end

      // pack the first three results in order
      for (int i = 0; i < 3; i++) res[i] = '0;
      k = 3'd0;
      for (int i = 0; i < 4; i++) begin
         if (e[i].vld && (k < 3'd3)) begin
            res[k[1:0]] = e[i].res;
            k = k + 1'b1;
         end
      end
      for (int i = 0; i < 3; i++) begin
         if (k == 3'(i + 1)) res[i].last = 1'b1;
      end

      next_state = n;
      res_count = k[1:0];
   end

endmodule

// ----- src/script_lexer_byte_tokenizer.sv -----
// top level of the streaming byte tokenizer: state registers and result buffer
// depends on sltok_pkg, sltok_scan and script_lexer_byte_tokenizer_macros.svh
`timescale 1ns / 1ps
// results are registered: a result is shown in the cycle after the byte beat that causes it
// throughput: one byte per cycle while each byte gives at most one result and the
// output does not stall; a byte giving two or three results stalls the input
// while the result buffer drains one beat per cycle when the output does not stall
// reset: synchronous, clears scan state, first_line back to 1, buffer empty

`include "script_lexer_byte_tokenizer_macros.svh"

module script_lexer_byte_tokenizer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_char_in,
   input  logic        req_is_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_result_kind,
   output logic [5:0]  rsp_token_type,
   output logic [23:0] rsp_line_number,
   output logic [23:0] rsp_start_offset,
   output logic [23:0] rsp_token_length,
   output logic [7:0]  rsp_bad_char,
   output logic        rsp_last_of_run,
   input  logic        csr_wr_en,
   input  logic [23:0] csr_wr_data
);

   // scan state and the first_line register
   sltok_pkg::state_type state_ff, state_in;
   logic [23:0] first_line_ff, first_line_in;

   // result buffer: up to three results of one byte, head at entry 0
   sltok_pkg::result_type res_ff [3];
   sltok_pkg::result_type res_in [3];
   logic [1:0] cnt_ff, cnt_in;

   sltok_pkg::state_type scan_state;
   sltok_pkg::result_type scan_res [3];
   logic [1:0] scan_cnt;

   logic req_take;
   logic rsp_take;

   sltok_scan u_scan (
      .cur_state  (state_ff),
      .char_in    (req_char_in),
      .is_last    (req_is_last),
      .first_line (first_line_ff),
      .next_state (scan_state),
      .res        (scan_res),
      .res_count  (scan_cnt)
   );

   // the buffer can take a new byte once it is empty or its last beat leaves now
   assign rsp_valid = (cnt_ff != 2'd0);
   assign rsp_take = rsp_valid && !rsp_stall;
   assign req_stall = !((cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && !rsp_stall));
   assign req_take = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      first_line_in = first_line_ff;
      if (req_take) state_in = scan_state;
      // a new first line applies at once while no byte of this source is in
      if (csr_wr_en) begin
         first_line_in = csr_wr_data;
         if ((state_ff.pos == '0) && (state_ff.mode == sltok_pkg::MODE_IDLE)) begin
            state_in.line = csr_wr_data;
         end
      end
   end

   always_comb begin
      res_in = res_ff;
      cnt_in = cnt_ff;
      if (req_take) begin
         res_in = scan_res;
         cnt_in = scan_cnt;
      end else if (rsp_take) begin
         // shift the next beat to the head
         res_in[0] = res_ff[1];
         res_in[1] = res_ff[2];
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '{mode: sltok_pkg::MODE_IDLE, line: 24'd1, default: '0};
         first_line_ff <= 24'd1;
         cnt_ff <= 2'd0;
      end else begin
         state_ff <= state_in;
         first_line_ff <= first_line_in;
         cnt_ff <= cnt_in;
      end
   end

   // payload only, no reset needed
   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   assign rsp_result_kind = res_ff[0].kind;
   assign rsp_token_type = res_ff[0].ttype;
   assign rsp_line_number = res_ff[0].line;
   assign rsp_start_offset = res_ff[0].start;
   assign rsp_token_length = res_ff[0].len;
   assign rsp_bad_char = res_ff[0].bad;
   assign rsp_last_of_run = res_ff[0].last;

   // a final byte always leaves at least the end-of-source beat
   `SLT_ASSERT_NEXT(a_last_gives_result, req_take && req_is_last, rsp_valid)
   // a final byte restarts the source position and mode
   `SLT_ASSERT_NEXT(a_last_restarts, req_take && req_is_last,
                    (state_ff.pos == '0) && (state_ff.mode == sltok_pkg::MODE_IDLE))
   // the only buffered beat closes its run
   `SLT_ASSERT_SAME(a_single_is_last, cnt_ff == 2'd1, res_ff[0].last)

endmodule
